### rtl/core/sfp_pkg.sv
`default_nettype none

package sfp_pkg;

    // Start marker that opens every frame ('$').
    localparam logic [7:0] START_MARKER = 8'h24;

    // Byte position inside a frame, one-hot. Hunting waits for the start marker.
    typedef enum logic [6:0] {
        POS_HUNT    = 7'b0000001,
        POS_NAME1   = 7'b0000010,
        POS_NAME2   = 7'b0000100,
        POS_PORT    = 7'b0001000,
        POS_DIST_LO = 7'b0010000,
        POS_DIST_HI = 7'b0100000,
        POS_CHECK   = 7'b1000000
    } pos_t;

    // Payload of one parsed frame.
    typedef struct packed {
        logic [7:0]  name_first;
        logic [7:0]  name_second;
        logic [7:0]  port_number;
        logic [15:0] distance;
    } frame_t;

endpackage

`default_nettype wire

### rtl/core/sfp_in_stage.sv
`default_nettype none

module sfp_in_stage
    import sfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register accepts a new byte when empty or when its byte leaves now.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

### rtl/core/sfp_parser.sv
`default_nettype none

module sfp_parser
    import sfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       byte_fire,
    input  wire logic [7:0] byte_data,
    output logic            res_valid,
    output frame_t          res_frame
);

    pos_t        pos_reg;
    pos_t        pos_next;
    logic [7:0]  xor_reg;
    logic [7:0]  xor_next;
    logic [7:0]  first_reg;
    logic [7:0]  first_next;
    logic [7:0]  second_reg;
    logic [7:0]  second_next;
    logic [7:0]  port_reg;
    logic [7:0]  port_next;
    logic [15:0] dist_reg;
    logic [15:0] dist_next;

    always_comb begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        first_next  = first_reg;
        second_next = second_reg;
        port_next   = port_reg;
        dist_next   = dist_reg;
        res_valid   = 1'b0;
        if (byte_fire) begin
            case (pos_reg)
                POS_HUNT: begin
                    if (byte_data == START_MARKER) begin
                        xor_next = xor_reg ^ byte_data;
                        pos_next = POS_NAME1;
                    end
                end
                POS_NAME1: begin
                    first_next = byte_data;
                    xor_next   = xor_reg ^ byte_data;
                    pos_next   = POS_NAME2;
                end
                POS_NAME2: begin
                    second_next = byte_data;
                    xor_next    = xor_reg ^ byte_data;
                    pos_next    = POS_PORT;
                end
                POS_PORT: begin
                    port_next = byte_data;
                    xor_next  = xor_reg ^ byte_data;
                    pos_next  = POS_DIST_LO;
                end
                POS_DIST_LO: begin
                    dist_next = {8'h00, byte_data};
                    xor_next  = xor_reg ^ byte_data;
                    pos_next  = POS_DIST_HI;
                end
                POS_DIST_HI: begin
                    dist_next = {byte_data, dist_reg[7:0]};
                    xor_next  = xor_reg ^ byte_data;
                    pos_next  = POS_CHECK;
                end
                POS_CHECK: begin
                    // A bad checksum drops the frame without a result.
                    res_valid = (xor_reg == byte_data);
                    xor_next  = 8'h00;
                    pos_next  = POS_HUNT;
                end
                default: begin
                    xor_next = 8'h00;
                    pos_next = POS_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            xor_reg <= 8'h00;
        end else begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg  <= first_next;
        second_reg <= second_next;
        port_reg   <= port_next;
        dist_reg   <= dist_next;
    end

    assign res_frame.name_first  = first_reg;
    assign res_frame.name_second = second_reg;
    assign res_frame.port_number = port_reg;
    assign res_frame.distance    = dist_reg;

    a_hunt_xor_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_HUNT) |-> (xor_reg == 8'h00))
        else $error("running checksum not clear while hunting");

    a_result_only_on_check: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (byte_fire && (pos_reg == POS_CHECK)))
        else $error("result raised outside the checksum byte");

    a_check_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_fire && (pos_reg == POS_CHECK)) |=> (pos_reg == POS_HUNT))
        else $error("parser did not return to hunting after the checksum byte");

endmodule

`default_nettype wire

### rtl/core/sfp_out_stage.sv
`default_nettype none

module sfp_out_stage
    import sfp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire frame_t  load_frame,
    output logic         free,
    output logic         m_valid,
    input  wire logic    m_ready,
    output frame_t       m_frame
);

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    // The result register can take a new frame when empty or being emptied.
    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= load_frame;
        end
    end

    assign m_valid = valid_reg;
    assign m_frame = frame_reg;

endmodule

`default_nettype wire

### rtl/core/sonar_frame_parser_core.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_rx_byte[7:0]
// m_        out        m_valid/m_ready    m_name_first, m_name_second, m_port_number,
//                                         m_distance[15:0]
//
// One request is taken per cycle while the result register has room; a result, if any,
// passes the input register, the rate-setting parser step and then the result register.
// Reset (aresetn low, synchronous) returns the parser to hunting for the start marker.
// When m_ready is low with a result held, the input register still fills and s_ready
// then drops until the result is taken.

module sonar_frame_parser_core
    import sfp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_name_first,
    output logic [7:0]       m_name_second,
    output logic [7:0]       m_port_number,
    output logic [15:0]      m_distance
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       take;
    logic       out_free;
    logic       res_valid;
    frame_t     res_frame;
    frame_t     out_frame;

    // A held byte is parsed only when the result register has room, so a
    // completed frame never needs to wait inside the parser.
    assign take = byte_valid && out_free;

    sfp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (take),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res_frame (res_frame)
    );

    sfp_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .load_frame (res_frame),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_frame    (out_frame)
    );

    assign m_name_first  = out_frame.name_first;
    assign m_name_second = out_frame.name_second;
    assign m_port_number = out_frame.port_number;
    assign m_distance    = out_frame.distance;

endmodule

`default_nettype wire

### tb/sv/sonar_frame_parser_core_test.sv
`timescale 1ns / 1ps

module sonar_frame_parser_core_test;
    import sfp_pkg::*;

    // Run limits. The drain wait covers the path through the input and result registers
    // with margin, and the cycle limit is many times the slowest legal run.
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int REPORT_LIMIT  = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_name_first;
    logic [7:0]  m_name_second;
    logic [7:0]  m_port_number;
    logic [15:0] m_distance;

    sonar_frame_parser_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_name_first  (m_name_first),
        .m_name_second (m_name_second),
        .m_port_number (m_port_number),
        .m_distance    (m_distance)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Our own copy of the parser state. It advances once per accepted request and
    // queues a frame whenever the checksum byte matches the running XOR.
    pos_t        parse_pos = POS_HUNT;
    logic [7:0]  parse_xor = 8'h00;
    frame_t      parse_fields = '0;
    frame_t      pending_frames[$];

    int bytes_parsed   = 0;
    int bytes_ignored  = 0;
    int frames_checked = 0;
    int mismatch_count = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    // Sender burst bookkeeping and the receiver's hold-off request, in cycles.
    int burst_left      = 0;
    int holdoff_request = 0;
    int holdoff_left    = 0;
    int rx_mode         = 0;
    int rx_cycle        = 0;

    task automatic track_frame_byte(input logic [7:0] b);
        if (parse_pos == POS_HUNT && b != START_MARKER) begin
            // Anything but the start marker is dropped while hunting.
            bytes_ignored++;
        end else begin
            bytes_parsed++;
            case (parse_pos)
                POS_HUNT: begin
                    parse_xor = b;
                    parse_pos = POS_NAME1;
                end
                POS_NAME1: begin
                    parse_fields.name_first = b;
                    parse_xor = parse_xor ^ b;
                    parse_pos = POS_NAME2;
                end
                POS_NAME2: begin
                    parse_fields.name_second = b;
                    parse_xor = parse_xor ^ b;
                    parse_pos = POS_PORT;
                end
                POS_PORT: begin
                    parse_fields.port_number = b;
                    parse_xor = parse_xor ^ b;
                    parse_pos = POS_DIST_LO;
                end
                POS_DIST_LO: begin
                    // The low byte replaces the whole held distance.
                    parse_fields.distance = {8'h00, b};
                    parse_xor = parse_xor ^ b;
                    parse_pos = POS_DIST_HI;
                end
                POS_DIST_HI: begin
                    parse_fields.distance[15:8] = b;
                    parse_xor = parse_xor ^ b;
                    parse_pos = POS_CHECK;
                end
                POS_CHECK: begin
                    // A bad checksum drops the frame silently; either way we hunt again.
                    if (parse_xor == b) begin
                        pending_frames.push_back(parse_fields);
                    end
                    parse_pos = POS_HUNT;
                    parse_xor = 8'h00;
                end
                default: begin
                    parse_pos = POS_HUNT;
                    parse_xor = 8'h00;
                end
            endcase
        end
    endtask

    // Offers one request and returns at the edge where it is accepted. Gaps between
    // bursts are inserted before raising valid, so valid is never dropped while a
    // request is pending and never gets two assignments in one time step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_frame_byte(b);
    endtask

    // Sends a complete seven-byte frame; a corrupted frame gets a nonzero
    // value folded into its checksum so it can never match.
    task automatic send_frame(input frame_t f, input bit corrupt);
        logic [7:0] checksum;
        checksum = START_MARKER ^ f.name_first ^ f.name_second ^ f.port_number
                   ^ f.distance[7:0] ^ f.distance[15:8];
        if (corrupt) begin
            checksum = checksum ^ 8'($urandom_range(1, 255));
        end
        send_byte(START_MARKER);
        send_byte(f.name_first);
        send_byte(f.name_second);
        send_byte(f.port_number);
        send_byte(f.distance[7:0]);
        send_byte(f.distance[15:8]);
        send_byte(checksum);
    endtask

    function automatic frame_t random_frame();
        frame_t f;
        f.name_first  = 8'($urandom_range(0, 255));
        f.name_second = 8'($urandom_range(0, 255));
        f.port_number = 8'($urandom_range(0, 255));
        f.distance    = 16'($urandom_range(0, 65535));
        // Now and then put the start marker into a data field.
        if ($urandom_range(0, 7) == 0) begin
            f.name_second = START_MARKER;
        end
        return f;
    endfunction

    // Stops offering requests until every expected frame has come back, then lets
    // the pipeline settle.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Bytes while hunting, including the neighbors of the marker, must be ignored.
    task automatic test_hunting_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h23);
        send_byte(8'h25);
        wait_for_drain();
    endtask

    // All-zero fields, then all-ones fields with the marker as a name byte.
    task automatic test_field_extremes();
        frame_t f;
        f = '0;
        send_frame(f, 1'b0);
        f.name_first  = START_MARKER;
        f.name_second = 8'hFF;
        f.port_number = 8'hFF;
        f.distance    = 16'hFFFF;
        send_frame(f, 1'b0);
        wait_for_drain();
    endtask

    // A frame with a wrong checksum must produce nothing.
    task automatic test_bad_checksum();
        send_frame(random_frame(), 1'b1);
        wait_for_drain();
    endtask

    // Mostly well-formed frames with random content; the rest are corrupted frames,
    // truncated frames that misalign the stream, and loose noise bytes.
    task automatic test_random_stream();
        int start;
        int kind;
        start = bytes_parsed;
        while (bytes_parsed - start < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(random_frame(), 1'b0);
            end else if (kind < 80) begin
                send_frame(random_frame(), 1'b1);
            end else if (kind < 90) begin
                send_byte(START_MARKER);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(($urandom_range(0, 3) == 0) ? START_MARKER
                                                         : 8'($urandom_range(0, 255)));
                end
            end
        end
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while good frames keep coming, so a
    // result sits in the output register and the block has to stall its input.
    task automatic test_backpressure_fill();
        holdoff_request = 150;
        repeat (6) send_frame(random_frame(), 1'b0);
        wait_for_drain();
    endtask

    // Receiver: a long hold-off when one is requested, otherwise one of several
    // stall patterns, each picked at random, including always ready.
    always @(posedge aclk) begin
        rx_cycle++;
        if (holdoff_request > 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_cycle % 64 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 1);
                2: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ((rx_cycle % 8) < 3);
            endcase
        end
    end

    // Each accepted result is matched against the oldest expected frame.
    always @(posedge aclk) begin : result_check
        frame_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                mismatch_count++;
                fail_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("tb: unexpected frame: name %02h %02h port %02h distance %04h",
                             m_name_first, m_name_second, m_port_number, m_distance);
                end
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (m_name_first !== want.name_first || m_name_second !== want.name_second
                    || m_port_number !== want.port_number || m_distance !== want.distance) begin
                    mismatch_count++;
                    fail_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("tb: mismatch: want %02h %02h %02h %04h, got %02h %02h %02h %04h",
                                 want.name_first, want.name_second, want.port_number,
                                 want.distance, m_name_first, m_name_second,
                                 m_port_number, m_distance);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_hunting_noise();
        test_field_extremes();
        test_bad_checksum();
        test_random_stream();
        test_backpressure_fill();

        // Anything still queued here never arrived.
        if (pending_frames.size() != 0) begin
            fail_count += pending_frames.size();
            $display("tb: %0d expected frames never arrived", pending_frames.size());
        end

        $display("tb: %0d bytes parsed, %0d ignored while hunting, %0d frames checked",
                 bytes_parsed, bytes_ignored, frames_checked);
        $display("tb: covered field extremes, bad checksums, markers inside frames, %s",
                 "truncated frames and output back-pressure");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/sfp_pkg.sv
rtl/core/sfp_in_stage.sv
rtl/core/sfp_parser.sv
rtl/core/sfp_out_stage.sv
rtl/core/sonar_frame_parser_core.sv
tb/sv/sonar_frame_parser_core_test.sv
